>>> sv/mersenne_twister_generator_core_defines.svh
// assertion macros for the checker file
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_DEFINES_SVH

// clocked on clk, switched off while rst_n is low
`define MTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked on clk, also checked through reset
`define MTG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mtg_pkg.sv
`default_nettype none

package mtg_pkg;

  // table geometry
  localparam int STATE_WORDS = 624;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int DATA_W      = 32;
  localparam int TWIST_SHIFT = 397;

  // algorithm constants
  localparam logic [DATA_W-1:0] SEED_RESET = 32'd5489;
  localparam logic [DATA_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam logic [DATA_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [DATA_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [DATA_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [DATA_W-1:0] TEMPER_C   = 32'hEFC6_0000;

  // write data select codes
  localparam logic [1:0] WSEL_SEED  = 2'd0;
  localparam logic [1:0] WSEL_MIX   = 2'd1;
  localparam logic [1:0] WSEL_TWIST = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic             mem_we;
    logic [1:0]       wsel;
    logic [IDX_W-1:0] waddr;
    logic             mem_re;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
    logic             mul_en;
    logic             cur_load;
    logic             out_load;
  } mtg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } mtg_status_t;

endpackage

`default_nettype wire

>>> sv/mtg_ctrl.sv
`default_nettype none

module mtg_ctrl
  import mtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_restart,
  output logic             in_ready,
  input  wire mtg_status_t status,
  output mtg_cmd_t         cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEED0  = 4'd1;
  localparam logic [3:0] ST_SMUL   = 4'd2;
  localparam logic [3:0] ST_SWR    = 4'd3;
  localparam logic [3:0] ST_TSTART = 4'd4;
  localparam logic [3:0] ST_TRD    = 4'd5;
  localparam logic [3:0] ST_TWR    = 4'd6;
  localparam logic [3:0] ST_RD     = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W:0]   FAR_OFS  = (IDX_W+1)'(TWIST_SHIFT);
  localparam logic [IDX_W:0]   WORDS_X  = (IDX_W+1)'(STATE_WORDS);

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             init_pend_r, init_pend_nxt;
  logic             draw_pend_r, draw_pend_nxt;

  logic [IDX_W-1:0] k_next_addr;
  logic [IDX_W:0]   far_sum;
  logic [IDX_W:0]   far_wrap;
  logic [IDX_W-1:0] far_addr;

  // neighbor addresses of the twist, modulo the table size
  assign k_next_addr = (k_r == LAST_IDX) ? '0 : k_r + IDX_W'(1);
  assign far_sum     = {1'b0, k_r} + FAR_OFS;
  assign far_wrap    = far_sum - WORDS_X;
  assign far_addr    = (far_sum >= WORDS_X) ? far_wrap[IDX_W-1:0] : far_sum[IDX_W-1:0];

  assign in_ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    init_pend_nxt = init_pend_r;
    draw_pend_nxt = draw_pend_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            draw_pend_nxt = 1'b0;
            state_nxt     = ST_SEED0;
          end else if (init_pend_r) begin
            draw_pend_nxt = 1'b1;
            state_nxt     = ST_SEED0;
          end else if (idx_r == '0) begin
            state_nxt = ST_TSTART;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_SEED0: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WSEL_SEED;
        cmd.waddr  = '0;
        k_nxt      = IDX_W'(1);
        state_nxt  = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SWR;
      end
      ST_SWR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WSEL_MIX;
        cmd.waddr  = k_r;
        if (k_r == LAST_IDX) begin
          idx_nxt       = '0;
          init_pend_nxt = 1'b0;
          state_nxt     = draw_pend_r ? ST_TSTART : ST_IDLE;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_SMUL;
        end
      end
      ST_TSTART: begin
        cmd.mem_re  = 1'b1;
        cmd.raddr_a = '0;
        k_nxt       = '0;
        state_nxt   = ST_TRD;
      end
      ST_TRD: begin
        cmd.mem_re   = 1'b1;
        cmd.raddr_a  = k_next_addr;
        cmd.raddr_b  = far_addr;
        cmd.cur_load = (k_r == '0);
        state_nxt    = ST_TWR;
      end
      ST_TWR: begin
        cmd.mem_we   = 1'b1;
        cmd.wsel     = WSEL_TWIST;
        cmd.waddr    = k_r;
        cmd.cur_load = 1'b1;
        if (k_r == LAST_IDX) begin
          state_nxt = ST_RD;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_TRD;
        end
      end
      ST_RD: begin
        cmd.mem_re  = 1'b1;
        cmd.raddr_a = idx_r;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          idx_nxt      = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      idx_r       <= '0;
      init_pend_r <= 1'b1;
      draw_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      init_pend_r <= init_pend_nxt;
      draw_pend_r <= draw_pend_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/mtg_datapath.sv
`default_nettype none

module mtg_datapath
  import mtg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  input  wire mtg_cmd_t          cmd,
  output mtg_status_t            status,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_random_value
);

  logic [DATA_W-1:0] mem [0:STATE_WORDS-1];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  logic [DATA_W-1:0] seed_r;
  logic [DATA_W-1:0] prev_r;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] cur_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic [DATA_W-1:0]   mix;
  logic [DATA_W-1:0]   prod_lo;
  logic [DATA_W-1:0]   twist_y;
  logic [DATA_W-1:0]   twist_w;
  logic [DATA_W-1:0]   wdata;
  logic [DATA_W-1:0]   tempered;

  function automatic logic [DATA_W-1:0] temper(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] t;
    t = x ^ (x >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // seeding recurrence multiply, low word only
  assign mix     = prev_r ^ (prev_r >> 30);
  assign prod_lo = SEED_MULT * mix;

  // twist of one word
  assign twist_y = (cur_r & UPPER_MASK) | (rdata_a_r & LOWER_MASK);
  assign twist_w = rdata_b_r ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

  // write data select
  always_comb begin
    unique case (cmd.wsel)
      WSEL_SEED:  wdata = seed_r;
      WSEL_MIX:   wdata = prod_r + {{(DATA_W-IDX_W){1'b0}}, cmd.waddr};
      WSEL_TWIST: wdata = twist_w;
      default:    wdata = '0;
    endcase
  end

  assign tempered        = temper(rdata_a_r);
  assign status.out_free = !out_valid_r || out_ready;

  // state table
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.waddr] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata_a_r <= mem[cmd.raddr_a];
      rdata_b_r <= mem[cmd.raddr_b];
    end
  end

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.mem_we && (cmd.wsel != WSEL_TWIST)) begin
      prev_r <= wdata;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_lo;
    end
    if (cmd.cur_load) begin
      cur_r <= rdata_a_r;
    end
    if (cmd.out_load) begin
      out_data_r <= tempered;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_data_r;

endmodule

`default_nettype wire

>>> sv/mersenne_twister_generator_core.sv
// MT19937 generator: a beat with in_restart high reseeds the 624-word table from the seed
// register and returns nothing; a beat with in_restart low returns one tempered 32-bit word.
// One item is worked at a time by a sequencer over a single table memory with two registered
// read ports and one write port. A plain draw reads the indexed word and tempers it into the
// result register once the output is free; the draw at index 0, which starts each run of 624,
// first twists the table word by word. Reseeding writes word 0 from the seed register and each
// further word through the seed multiplier. The first draw after reset seeds from the current
// seed register before it twists. A seed written later takes effect at the next restart. The
// result register lets a new beat be taken while a word still waits on the output.
`default_nettype none

module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_random_value
);

  mtg_cmd_t    cmd;
  mtg_status_t status;

  // sequencer
  mtg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // table, seeding, twist and tempering
  mtg_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

endmodule

`default_nettype wire

>>> sv/mtg_checker.sv
`default_nettype none

`include "mersenne_twister_generator_core_defines.svh"

module mtg_checker
  import mtg_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_restart,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_random_value
);

  // one item at a time: busy right after any accepted beat
  `MTG_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after accept")

  // a restart never produces a result beat
  `MTG_ASSERT(a_restart_silent, in_valid && in_ready && in_restart |=> !$rose(out_valid), "restart made output")

  // stalled result holds its word
  `MTG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_random_value), "output dropped")

  // reset empties the output and opens the input
  `MTG_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_restart       (in_restart),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_random_value (out_random_value)
);

`default_nettype wire
